// File: hdl/sha256_stream_hasher_unit_macros.svh
// ---------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Immediate-cycle and next-cycle implication checks, clocked on clk and
// quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/shs_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash values, sigma functions and the command and
// status types between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package shs_pkg;

    // byte source for the message shift register
    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_PAD  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    typedef struct packed {
        logic       shift_en;
        logic [1:0] byte_sel;
        logic       count_inc;
        logic       start_blk;
        logic       round_en;
        logic [5:0] round_idx;
        logic       fold_en;
        logic       restore_iv;
        logic [2:0] out_idx;
    } shs_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
    } shs_stat_t;

    function automatic logic [31:0] shs_rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] shs_bsig0(input logic [31:0] x);
        return shs_rotr(x, 2) ^ shs_rotr(x, 13) ^ shs_rotr(x, 22);
    endfunction

    function automatic logic [31:0] shs_bsig1(input logic [31:0] x);
        return shs_rotr(x, 6) ^ shs_rotr(x, 11) ^ shs_rotr(x, 25);
    endfunction

    function automatic logic [31:0] shs_ssig0(input logic [31:0] x);
        return shs_rotr(x, 7) ^ shs_rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] shs_ssig1(input logic [31:0] x);
        return shs_rotr(x, 17) ^ shs_rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] shs_iv(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] shs_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// File: hdl/shs_datapath.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher datapath
// Message/schedule shift register, round variables, hash words, byte count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shs_datapath
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  shs_cmd_t    cmd,
    input  logic [7:0]  data_byte,
    output shs_stat_t   stat,
    output logic [31:0] digest_word
);

    // word i of the block sits at msg_reg[511-32i -: 32]
    logic [511:0] msg_reg, msg_next;
    logic [31:0]  vars_reg [8];
    logic [31:0]  hash_reg [8];
    logic [63:0]  count_reg;
    logic [5:0]   fill_reg;

    logic [7:0]  byte_in;
    logic [63:0] len_bits, len_shift;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2;

    assign len_bits  = {count_reg[60:0], 3'b000};
    assign len_shift = len_bits << {fill_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_DATA: byte_in = data_byte;
            SEL_PAD:  byte_in = PAD_BYTE;
            SEL_LEN:  byte_in = len_shift[63:56];
            default:  byte_in = 8'h00;
        endcase
    end

    assign w0  = msg_reg[511:480];
    assign w1  = msg_reg[479:448];
    assign w9  = msg_reg[223:192];
    assign w14 = msg_reg[63:32];
    assign w_new = shs_ssig1(w14) + w9 + shs_ssig0(w1) + w0;

    assign t1 = vars_reg[7] + shs_bsig1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + shs_k(cmd.round_idx) + w0;
    assign t2 = shs_bsig0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        msg_next = msg_reg;
        if (cmd.shift_en)
        begin
            msg_next = {msg_reg[503:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            msg_next = {msg_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
        if (cmd.start_blk)
        begin
            for (int i = 0; i < 8; i++)
            begin
                vars_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            vars_reg[0] <= t1 + t2;
            vars_reg[1] <= vars_reg[0];
            vars_reg[2] <= vars_reg[1];
            vars_reg[3] <= vars_reg[2];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[5] <= vars_reg[4];
            vars_reg[6] <= vars_reg[5];
            vars_reg[7] <= vars_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= shs_iv(3'(i));
            end
            count_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            if (cmd.restore_iv)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= shs_iv(3'(i));
                end
            end
            else if (cmd.fold_en)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + vars_reg[i];
                end
            end
            if (cmd.restore_iv)
            begin
                count_reg <= '0;
            end
            else if (cmd.count_inc)
            begin
                count_reg <= count_reg + 64'd1;
            end
            if (cmd.shift_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
        end
    end

    assign stat.fill   = fill_reg;
    assign digest_word = hash_reg[cmd.out_idx];

endmodule

// File: hdl/shs_ctrl.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher controller
// Sequences byte intake, padding, 64 rounds, fold and digest readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shs_ctrl
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [2:0]  word_index,
    output logic        last_word,
    input  shs_stat_t   stat,
    output shs_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] widx_reg, widx_next;
    logic       eom_reg, eom_next;      // close pending after this block
    logic       pad_reg, pad_next;      // padding in progress
    logic       first_reg, first_next;  // next pad byte is 0x80
    logic       lenph_reg, lenph_next;  // this block carries the length
    logic       final_reg, final_next;  // block under compression is the last

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        eom_next   = eom_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        lenph_next = lenph_reg;
        final_next = final_reg;

        data_ready   = 1'b0;
        digest_valid = 1'b0;

        cmd            = '0;
        cmd.byte_sel   = SEL_ZERO;
        cmd.round_idx  = rnd_reg;
        cmd.out_idx    = widx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                data_ready = 1'b1;
                if (data_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.shift_en  = 1'b1;
                        cmd.byte_sel  = SEL_DATA;
                        cmd.count_inc = 1'b1;
                    end
                    if (byte_valid && stat.fill == FILL_LAST)
                    begin
                        cmd.start_blk = 1'b1;
                        rnd_next      = '0;
                        eom_next      = end_of_message;
                        state_next    = ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        lenph_next = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold_en = 1'b1;
                if (final_reg)
                begin
                    final_next = 1'b0;
                    widx_next  = '0;
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (eom_reg)
                begin
                    eom_next   = 1'b0;
                    pad_next   = 1'b1;
                    first_next = 1'b1;
                    lenph_next = 1'b0;
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                first_next   = 1'b0;
                if (first_reg)
                begin
                    cmd.byte_sel = SEL_PAD;
                    lenph_next   = (stat.fill < LEN_START);
                end
                else if (lenph_reg && stat.fill >= LEN_START)
                begin
                    cmd.byte_sel = SEL_LEN;
                end
                if (stat.fill == FILL_LAST)
                begin
                    // block full: the length went in only if this was a length byte
                    cmd.start_blk = 1'b1;
                    rnd_next      = '0;
                    final_next    = lenph_reg && !first_reg;
                    lenph_next    = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                digest_valid = 1'b1;
                if (digest_ready)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == WORD_LAST)
                    begin
                        cmd.restore_iv = 1'b1;
                        pad_next       = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            widx_reg  <= '0;
            eom_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            lenph_reg <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
            eom_reg   <= eom_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            lenph_reg <= lenph_next;
            final_reg <= final_next;
        end
    end

    assign word_index = widx_reg;
    assign last_word  = (widx_reg == WORD_LAST);

endmodule

// File: hdl/sha256_stream_hasher_unit.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher, top level
// Hashes a byte stream and returns the eight 32-bit digest words per message.
// ---------------------------------------------------------------------------
// Input channel (data_valid/data_ready): one beat carries data_byte, byte_valid
// and end_of_message. byte_valid low with end_of_message high closes a message
// without adding a byte (an empty message hashes to the empty-string digest);
// both low is an idle beat that changes nothing.
// Output channel (digest_valid/digest_ready): eight beats per closed message,
// H0 first, word_index 0..7, last_word high on the eighth.
// Throughput: one byte per cycle while a block fills; the 64th byte starts
// the rounds on the shared round unit and then the fold, during which
// data_ready is low.
// On close: padding is shifted in one byte a cycle up to the block end, then
// the block is compressed and folded; when fewer than 9 bytes are left after
// the data, a second padding block is shifted in and compressed before the
// first digest beat.
// The block handles one message at a time: data_ready stays low from the
// closing beat until the eighth digest beat is taken. A stalled receiver just
// holds the current digest beat. Reset loads the initial hash values, clears
// the byte count and leaves the block ready for a new message.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_stream_hasher_unit_macros.svh"

module sha256_stream_hasher_unit
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    shs_cmd_t  cmd;   // controller -> datapath
    shs_stat_t stat;  // datapath -> controller (block fill)

    shs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .data_ready     (data_ready),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_ready   (digest_ready),
        .word_index     (word_index),
        .last_word      (last_word),
        .stat           (stat),
        .cmd            (cmd)
    );

    shs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .stat        (stat),
        .digest_word (digest_word)
    );

    // intake and readout never overlap
    `SHS_ASSERT_NOW(a_no_overlap, digest_valid, !data_ready, "intake open during readout")
    // readout only once the final block has ended exactly on a block boundary
    `SHS_ASSERT_NOW(a_fill_empty, digest_valid, stat.fill == 6'd0, "digest with partial block")
    // a closing beat always leaves the intake busy
    `SHS_ASSERT_NEXT(a_close_busy, data_valid && data_ready && end_of_message, !data_ready,
                     "intake reopened right after close")
    // last digest beat returns the block to intake
    `SHS_ASSERT_NEXT(a_back_idle, digest_valid && digest_ready && last_word, data_ready,
                     "not ready after digest")

endmodule
